>>> sv/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	// Operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_STATUS = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;

	typedef struct packed {
		logic [1:0]               op;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] popped_value;
		logic signed [DATA_W-1:0] head_value;
		logic signed [DATA_W-1:0] tail_value;
		logic [COUNT_W-1:0]       count;
		logic                     is_empty;
	} rsp_t;

	// Broadcast to every cell of the chain
	typedef struct packed {
		logic                     ins;
		logic                     pop;
		logic signed [DATA_W-1:0] value;
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
	input  wire logic                             clk,
	input  wire spq_pkg::cell_ctrl_t              ctrl,
	input  wire logic                             occupied,
	input  wire logic                             left_lt,
	input  wire logic signed [spq_pkg::DATA_W-1:0] left_value,
	input  wire logic signed [spq_pkg::DATA_W-1:0] right_value,
	output logic                                  lt,
	output logic signed [spq_pkg::DATA_W-1:0]     value_q
);
	import spq_pkg::*;

	// The new value goes behind this cell when it is strictly greater
	assign lt = occupied && (ctrl.value > value_q);

	// Keep, take the new value, shift in from the left on insert; from the right on pop
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!lt) begin
				value_q <= left_lt ? ctrl.value : left_value;
			end
		end else if (ctrl.pop) begin
			value_q <= right_value;
		end
	end

endmodule

`default_nettype wire

>>> sv/sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted priority queue built as a chain of CAPACITY compare-and-shift cells.
// Values are signed Q16.16, kept ascending with the smallest at the head; an
// insert lands ahead of the first stored value greater than or equal to it,
// so the newest of equal values stands first. Every cell compares against the
// request value in parallel and shifts by one place, so one request is taken
// per clock while the output is not stalled, and its result appears in an
// output register in the cycle after the request is taken.
// Pop on an empty queue reports status EMPTY; insert into a full queue is
// dropped and reports FULL. The count field shows the fill masked to 5 bits.
module sorted_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire spq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output spq_pkg::rsp_t      rsp
);
	import spq_pkg::*;

	localparam int FILL_W = $clog2(CAPACITY + 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CAPACITY);

	logic                     accept;
	logic [FILL_W-1:0]        fill_q;
	logic [FILL_W-1:0]        fill_n;
	logic signed [DATA_W-1:0] tail_q;
	logic signed [DATA_W-1:0] tail_n;
	logic signed [DATA_W-1:0] head_n;
	logic                     is_full;
	logic                     is_empty_now;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;
	rsp_t                     rsp_n;
	cell_ctrl_t               ctrl;
	logic [CAPACITY-1:0]      lt_v;
	logic signed [DATA_W-1:0] vals [CAPACITY];

	// Take a request whenever the output register is free or being drained
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign is_full      = (fill_q == FILL_MAX);
	assign is_empty_now = (fill_q == '0);

	assign ctrl.ins   = accept && (req.op == OP_INSERT) && !is_full;
	assign ctrl.pop   = accept && (req.op == OP_POP) && !is_empty_now;
	assign ctrl.value = req.value;

	// Chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     left_lt;
		logic signed [DATA_W-1:0] left_value;
		logic signed [DATA_W-1:0] right_value;

		if (i == 0) begin : g_first
			assign left_lt    = 1'b1;
			assign left_value = req.value;
		end else begin : g_mid
			assign left_lt    = lt_v[i-1];
			assign left_value = vals[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_value = vals[i];
		end else begin : g_inner
			assign right_value = vals[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (fill_q > FILL_W'(i)),
			.left_lt     (left_lt),
			.left_value  (left_value),
			.right_value (right_value),
			.lt          (lt_v[i]),
			.value_q     (vals[i])
		);
	end

	// Work out fill, head, tail and the response after this request
	always_comb begin
		fill_n = fill_q;
		head_n = vals[0];
		tail_n = tail_q;
		rsp_n  = '0;
		unique case (req.op)
			OP_INSERT: begin
				if (is_full) begin
					rsp_n.status = ST_FULL;
				end else begin
					fill_n = fill_q + FILL_W'(1);
					head_n = lt_v[0] ? vals[0] : req.value;
					if (is_empty_now || (req.value > tail_q)) begin
						tail_n = req.value;
					end
				end
			end
			OP_POP: begin
				if (is_empty_now) begin
					rsp_n.status = ST_EMPTY;
				end else begin
					fill_n             = fill_q - FILL_W'(1);
					head_n             = vals[1];
					rsp_n.popped_value = vals[0];
				end
			end
			OP_CLEAR: begin
				fill_n = '0;
			end
			OP_STATUS: begin
			end
			default: begin
			end
		endcase
		if (fill_n != '0) begin
			rsp_n.head_value = head_n;
			rsp_n.tail_value = tail_n;
		end
		rsp_n.count    = COUNT_W'(fill_n);
		rsp_n.is_empty = (fill_n == '0);
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_n;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Advance tail and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			tail_q <= tail_n;
			rsp_q  <= rsp_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
